// File: design/csca_pkg.sv
// ----------------------------------------------------------------------------
// csca_pkg: shared types and constants for the channel shuffle address unit
// Widths, status codes, register indexes and the words passed between stages.
// ----------------------------------------------------------------------------
package csca_pkg;

    localparam int BLOCK_CH   = 4;
    localparam int LANE_W     = 2;
    localparam int IN_CH_W    = 12;
    localparam int CH_W       = 13;
    localparam int PAD_W      = 14;
    localparam int BATCH_W    = 8;
    localparam int PIXEL_W    = 20;
    localparam int PLANE_W    = 21;
    localparam int OFF_W      = 39;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int OFF_STAGES = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUPS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE     = 3'd4;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_ODD_SPLIT = 2'd1,
        STATUS_RANGE     = 2'd2
    } status_t;

    // per-word data carried alongside the divider chain
    typedef struct packed {
        logic [BATCH_W-1:0] batch;
        logic [PIXEL_W-1:0] pixel;
        status_t            status;
        logic               dsel;
        logic               zf;
        logic [CH_W-1:0]    local_ch;
        logic [PAD_W-1:0]   dpad;
    } side_t;

    // two restoring divisions by the group count, one bit per cell
    typedef struct packed {
        logic [CH_W-1:0] num_a;
        logic [CH_W-1:0] rem_a;
        logic [CH_W-1:0] quo_a;
        logic [CH_W-1:0] num_b;
        logic [CH_W-1:0] rem_b;
        logic [CH_W-1:0] quo_b;
        side_t           side;
    } div_t;

    typedef struct packed {
        status_t status;
        logic    dsel;
        logic    zf;
        logic    ssel;
    } info_t;

    typedef struct packed {
        logic             source_select;
        logic [OFF_W-1:0] source_offset;
        logic             dest_select;
        logic [OFF_W-1:0] dest_offset;
        logic             zero_fill;
        status_t          status;
    } res_t;

    // round a channel count up to a whole block
    function automatic logic [PAD_W-1:0] pad_up(input logic [PAD_W-1:0] c);
        logic [PAD_W-1:0] s;
        s = c + PAD_W'(BLOCK_CH - 1);
        return {s[PAD_W-1:LANE_W], LANE_W'(0)};
    endfunction

endpackage

// File: design/csca_div_cell.sv
// ----------------------------------------------------------------------------
// csca_div_cell: one cell of the divider chain
// Does one restoring step of oc / g and of C / g, passes the side data on.
// ----------------------------------------------------------------------------
module csca_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [csca_pkg::CH_W-1:0] divisor,
    input  logic                      in_valid,
    input  csca_pkg::div_t            in_data,
    output logic                      out_valid,
    output csca_pkg::div_t            out_data
);
    import csca_pkg::*;

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [CH_W:0]    t_a;
    logic [CH_W:0]    t_b;
    logic [CH_W:0]    diff_a;
    logic [CH_W:0]    diff_b;
    logic             ge_a;
    logic             ge_b;

    always_comb
    begin
        t_a    = {in_data.rem_a, in_data.num_a[CH_W-1]};
        t_b    = {in_data.rem_b, in_data.num_b[CH_W-1]};
        ge_a   = t_a >= {1'b0, divisor};
        ge_b   = t_b >= {1'b0, divisor};
        diff_a = t_a - {1'b0, divisor};
        diff_b = t_b - {1'b0, divisor};

        data_next       = in_data;
        // remainder stays below the divisor, so it fits CH_W bits
        data_next.rem_a = ge_a ? diff_a[CH_W-1:0] : t_a[CH_W-1:0];
        data_next.rem_b = ge_b ? diff_b[CH_W-1:0] : t_b[CH_W-1:0];
        data_next.quo_a = {in_data.quo_a[CH_W-2:0], ge_a};
        data_next.quo_b = {in_data.quo_b[CH_W-2:0], ge_b};
        data_next.num_a = {in_data.num_a[CH_W-2:0], 1'b0};
        data_next.num_b = {in_data.num_b[CH_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/csca_offset.sv
// ----------------------------------------------------------------------------
// csca_offset: blocked tensor offset, three stages
// (b*Q + (k & ~3))*P + p*4 + (k & 3), wrapped to the offset width.
// ----------------------------------------------------------------------------
module csca_offset (
    input  logic                         clk,
    input  logic                         en,
    input  logic [csca_pkg::BATCH_W-1:0] batch,
    input  logic [csca_pkg::PAD_W-1:0]   pad,
    input  logic [csca_pkg::PAD_W-1:0]   chan,
    input  logic [csca_pkg::PIXEL_W-1:0] pixel,
    input  logic [csca_pkg::PLANE_W-1:0] plane,
    output logic [csca_pkg::OFF_W-1:0]   offset
);
    import csca_pkg::*;

    localparam int BQ_W   = BATCH_W + PAD_W;
    localparam int TAIL_W = PIXEL_W + LANE_W;
    localparam int PROD_W = BQ_W + PLANE_W;

    logic [BQ_W-1:0]   m1_bq_reg;
    logic [BQ_W-1:0]   m1_bq_next;
    logic [TAIL_W-1:0] m1_tail_reg;
    logic [PROD_W-1:0] prod_full;
    logic [OFF_W-1:0]  m2_prod_reg;
    logic [TAIL_W-1:0] m2_tail_reg;
    logic [OFF_W-1:0]  m3_off_reg;

    assign m1_bq_next = BQ_W'(batch) * BQ_W'(pad)
                      + BQ_W'({chan[PAD_W-1:LANE_W], LANE_W'(0)});
    assign prod_full  = PROD_W'(m1_bq_reg) * PROD_W'(plane);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_bq_reg   <= m1_bq_next;
            m1_tail_reg <= {pixel, chan[LANE_W-1:0]};
            m2_prod_reg <= prod_full[OFF_W-1:0];
            m2_tail_reg <= m1_tail_reg;
            m3_off_reg  <= m2_prod_reg + OFF_W'(m2_tail_reg);
        end
    end

    assign offset = m3_off_reg;

endmodule

// File: design/csca_skid.sv
// ----------------------------------------------------------------------------
// csca_skid: output register with one skid entry
// Holds back the pipeline only once both entries are taken.
// ----------------------------------------------------------------------------
module csca_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  csca_pkg::res_t  push_data,
    input  logic            out_stall,
    output logic            out_valid,
    output csca_pkg::res_t  out_data,
    output logic            full
);
    import csca_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic pop;
    logic push;

    assign pop  = out_valid_reg && !out_stall;
    assign push = push_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= push_data;
            end
            else
            begin
                skid_data_reg <= push_data;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

// File: design/channel_shuffle_concat_split_addr.sv
// ----------------------------------------------------------------------------
// channel_shuffle_concat_split_addr: channel shuffle copy address generator
// Maps a padded output slot and pixel to source and destination offsets for
// blocked four-channel tensors, with concatenated inputs and optional split.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | batch_index, out_slot, pixel_index
//  out     | output    | out_valid/out_stall | source_select, source_offset,
//          |           |                   | dest_select, dest_offset,
//          |           |                   | zero_fill, status
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// One word per cycle in and out while the output is not stalled; a word passes
// the front stage, 13 divider cells, two shuffle stages, three offset stages
// and the output register. The divider chain makes up most of the pipeline.
// Reset leaves the pipeline empty and the registers at their defaults.
// A stalled output fills the skid entry, after which in_stall rises and the
// whole pipeline holds.
// ----------------------------------------------------------------------------
module channel_shuffle_concat_split_addr (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csca_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [csca_pkg::BATCH_W-1:0]    batch_index,
    input  logic [csca_pkg::CH_W-1:0]       out_slot,
    input  logic [csca_pkg::PIXEL_W-1:0]    pixel_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            source_select,
    output logic [csca_pkg::OFF_W-1:0]      source_offset,
    output logic                            dest_select,
    output logic [csca_pkg::OFF_W-1:0]      dest_offset,
    output logic                            zero_fill,
    output logic [1:0]                      status
);
    import csca_pkg::*;

    // configuration
    logic [IN_CH_W-1:0] first_ch_reg;
    logic [IN_CH_W-1:0] second_ch_reg;
    logic [CH_W-1:0]    group_reg;
    logic               split_reg;
    logic [PLANE_W-1:0] plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_ch_reg  <= '0;
            second_ch_reg <= '0;
            group_reg     <= CH_W'(1);
            split_reg     <= 1'b0;
            plane_reg     <= PLANE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_CH:  first_ch_reg  <= cfg_data[IN_CH_W-1:0];
                REG_SECOND_CH: second_ch_reg <= cfg_data[IN_CH_W-1:0];
                REG_GROUPS:    group_reg     <= cfg_data[CH_W-1:0];
                REG_SPLIT:     split_reg     <= cfg_data[0];
                REG_PLANE:     plane_reg     <= cfg_data[PLANE_W-1:0];
                default:       ;
            endcase
        end
    end

    logic            pipe_en;
    logic            skid_full;
    logic [CH_W-1:0] chans;
    logic [CH_W-1:0] group_eff;

    assign pipe_en   = !skid_full;
    assign in_stall  = skid_full;
    assign chans     = CH_W'(first_ch_reg) + CH_W'(second_ch_reg);
    assign group_eff = (group_reg == '0) ? CH_W'(1) : group_reg;

    // front stage: slot decode
    logic [CH_W-1:0]  o1;
    logic [CH_W-1:0]  o2;
    logic [PAD_W-1:0] po1;
    logic [PAD_W-1:0] po2;
    logic [PAD_W-1:0] slot_w;
    logic [PAD_W-1:0] rel;
    logic             in_first;
    logic             in_second;
    logic             odd_split;
    logic [CH_W-1:0]  dlimit;
    side_t            a_side_next;
    logic [CH_W-1:0]  a_oc_next;
    logic             a_valid_reg;
    side_t            a_side_reg;
    logic [CH_W-1:0]  a_oc_reg;

    always_comb
    begin
        odd_split = split_reg && chans[0];
        o1        = split_reg ? {1'b0, chans[CH_W-1:1]} : chans;
        o2        = split_reg ? {1'b0, chans[CH_W-1:1]} : '0;
        po1       = pad_up(PAD_W'(o1));
        po2       = pad_up(PAD_W'(o2));
        slot_w    = PAD_W'(out_slot);
        rel       = slot_w - po1;
        in_first  = slot_w < po1;
        in_second = rel < po2;

        a_side_next        = '0;
        a_side_next.batch  = batch_index;
        a_side_next.pixel  = pixel_index;
        if (in_first)
        begin
            a_side_next.dsel     = 1'b0;
            a_side_next.local_ch = out_slot;
            a_side_next.dpad     = po1;
            dlimit               = o1;
            a_oc_next            = out_slot;
        end
        else
        begin
            a_side_next.dsel     = 1'b1;
            a_side_next.local_ch = rel[CH_W-1:0];
            a_side_next.dpad     = po2;
            dlimit               = o2;
            a_oc_next            = o1 + rel[CH_W-1:0];
        end

        if (odd_split)
        begin
            a_side_next.status = STATUS_ODD_SPLIT;
        end
        else if (!in_first && !in_second)
        begin
            a_side_next.status = STATUS_RANGE;
        end
        else
        begin
            a_side_next.status = STATUS_OK;
        end
        a_side_next.zf = (a_side_next.local_ch >= dlimit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_side_reg <= a_side_next;
            a_oc_reg   <= a_oc_next;
        end
    end

    // divider chain: oc / g, oc % g and C / g
    logic cell_valid [0:CH_W];
    div_t cell_data  [0:CH_W];

    always_comb
    begin
        cell_valid[0]      = a_valid_reg;
        cell_data[0]       = '0;
        cell_data[0].num_a = a_oc_reg;
        cell_data[0].num_b = chans;
        cell_data[0].side  = a_side_reg;
    end

    genvar k;
    generate
        for (k = 0; k < CH_W; k++)
        begin : g_cell
            csca_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (pipe_en),
                .divisor   (group_eff),
                .in_valid  (cell_valid[k]),
                .in_data   (cell_data[k]),
                .out_valid (cell_valid[k+1]),
                .out_data  (cell_data[k+1])
            );
        end
    endgenerate

    // shuffle: ic = (oc % g) * (C / g) + oc / g
    logic [2*CH_W-1:0] prod_full;
    logic              b_valid_reg;
    side_t             b_side_reg;
    logic [PAD_W-1:0]  b_prod_reg;
    logic [CH_W-1:0]   b_q1_reg;

    assign prod_full = (2*CH_W)'(cell_data[CH_W].rem_a) * (2*CH_W)'(cell_data[CH_W].quo_b);

    logic [PAD_W-1:0] ic;
    logic [PAD_W-1:0] c1_w;
    logic             ssel_next;
    logic [PAD_W-1:0] sch_next;
    logic [PAD_W-1:0] spad_next;
    logic             c_valid_reg;
    side_t            c_side_reg;
    logic             c_ssel_reg;
    logic [PAD_W-1:0] c_sch_reg;
    logic [PAD_W-1:0] c_spad_reg;

    always_comb
    begin
        c1_w      = PAD_W'(first_ch_reg);
        ic        = b_prod_reg + PAD_W'(b_q1_reg);
        ssel_next = ic >= c1_w;
        sch_next  = ssel_next ? (ic - c1_w) : ic;
        spad_next = pad_up(ssel_next ? PAD_W'(second_ch_reg) : c1_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            b_valid_reg <= cell_valid[CH_W];
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            // product stays below C, so the low bits hold it
            b_prod_reg <= prod_full[PAD_W-1:0];
            b_q1_reg   <= cell_data[CH_W].quo_a;
            b_side_reg <= cell_data[CH_W].side;
            c_side_reg <= b_side_reg;
            c_ssel_reg <= ssel_next;
            c_sch_reg  <= sch_next;
            c_spad_reg <= spad_next;
        end
    end

    // offsets
    logic [OFF_W-1:0] src_off;
    logic [OFF_W-1:0] dst_off;

    csca_offset u_src_off (
        .clk    (clk),
        .en     (pipe_en),
        .batch  (c_side_reg.batch),
        .pad    (c_spad_reg),
        .chan   (c_sch_reg),
        .pixel  (c_side_reg.pixel),
        .plane  (plane_reg),
        .offset (src_off)
    );

    csca_offset u_dst_off (
        .clk    (clk),
        .en     (pipe_en),
        .batch  (c_side_reg.batch),
        .pad    (c_side_reg.dpad),
        .chan   (PAD_W'(c_side_reg.local_ch)),
        .pixel  (c_side_reg.pixel),
        .plane  (plane_reg),
        .offset (dst_off)
    );

    logic  d_valid_reg [0:OFF_STAGES-1];
    info_t d_info_reg  [0:OFF_STAGES-1];
    info_t d_info_next;

    always_comb
    begin
        d_info_next.status = c_side_reg.status;
        d_info_next.dsel   = c_side_reg.dsel;
        d_info_next.zf     = c_side_reg.zf;
        d_info_next.ssel   = c_ssel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < OFF_STAGES; i++)
            begin
                d_valid_reg[i] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            d_valid_reg[0] <= c_valid_reg;
            for (int i = 1; i < OFF_STAGES; i++)
            begin
                d_valid_reg[i] <= d_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            d_info_reg[0] <= d_info_next;
            for (int i = 1; i < OFF_STAGES; i++)
            begin
                d_info_reg[i] <= d_info_reg[i-1];
            end
        end
    end

    // result word: errors clear everything but the status, pad lanes clear the source
    res_t  res_word;
    info_t last_info;

    assign last_info = d_info_reg[OFF_STAGES-1];

    always_comb
    begin
        res_word        = '0;
        res_word.status = last_info.status;
        if (last_info.status == STATUS_OK)
        begin
            res_word.dest_select = last_info.dsel;
            res_word.dest_offset = dst_off;
            res_word.zero_fill   = last_info.zf;
            if (!last_info.zf)
            begin
                res_word.source_select = last_info.ssel;
                res_word.source_offset = src_off;
            end
        end
    end

    res_t out_word;

    csca_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (d_valid_reg[OFF_STAGES-1]),
        .push_data  (res_word),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_word),
        .full       (skid_full)
    );

    assign source_select = out_word.source_select;
    assign source_offset = out_word.source_offset;
    assign dest_select   = out_word.dest_select;
    assign dest_offset   = out_word.dest_offset;
    assign zero_fill     = out_word.zero_fill;
    assign status        = out_word.status;

endmodule
